### hw/rtl/mccs_pkg.sv
package mccs_pkg;

  localparam int DATA_W = 16;
  localparam int COIL_W = 3;
  localparam int MASK_W = 8;

  typedef enum logic [1:0] {
    OP_TICK    = 2'd0,
    OP_CAPTURE = 2'd1,
    OP_TARE    = 2'd2,
    OP_READ    = 2'd3
  } op_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_RESP = 1'b1
  } state_t;

  typedef struct packed {
    logic              tick;
    logic              mask_we;
    logic [MASK_W-1:0] mask;
  } rotor_ctl_t;

endpackage

### hw/rtl/mccs_ram.sv
module mccs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### hw/rtl/mccs_rotor.sv
module mccs_rotor #(
  parameter int COIL_COUNT = 8
) (
  input  logic                       clk,
  input  logic                       rst,
  input  mccs_pkg::rotor_ctl_t       ctl,
  output logic [mccs_pkg::COIL_W-1:0] current_coil
);

  logic [mccs_pkg::MASK_W-1:0] active_coil_mask;
  logic [mccs_pkg::COIL_W-1:0] current_coil_next;
  logic [mccs_pkg::COIL_W:0]   cand;
  logic                        found;

  always_comb begin
    current_coil_next = '0;
    found             = 1'b0;
    cand              = '0;
    for (int i = 1; i < COIL_COUNT; i++) begin
      cand = {1'b0, current_coil} + (mccs_pkg::COIL_W + 1)'(i);
      if (cand >= (mccs_pkg::COIL_W + 1)'(COIL_COUNT)) begin
        cand = cand - (mccs_pkg::COIL_W + 1)'(COIL_COUNT);
      end
      if (!found && active_coil_mask[cand[mccs_pkg::COIL_W-1:0]]) begin
        current_coil_next = cand[mccs_pkg::COIL_W-1:0];
        found             = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active_coil_mask <= mccs_pkg::MASK_W'(1);
      current_coil     <= '0;
    end else begin
      if (ctl.mask_we) begin
        active_coil_mask <= ctl.mask;
      end
      if (ctl.tick) begin
        current_coil <= current_coil_next;
      end
    end
  end

endmodule

### hw/rtl/multi_coil_capture_sequencer.sv
// channel  | handshake             | payload
// cfg      | cfg_valid / cfg_ready | cfg_data (active_coil_mask)
// in       | in_valid / in_ready   | opcode, timer_value, coil_index
// out      | out_valid / out_ready | selected_coil, read_shift, read_capture, read_tare
//
// Each transaction is accepted, then waits in the response state for the registered
// read of the capture and tare RAMs before the result is loaded.
// A new transaction is taken while the previous result waits in the output register.
// Reset is synchronous; per-coil valid bits make both stores read as zero at once.
// A stalled output holds the second transaction in the response state.
module multi_coil_capture_sequencer #(
  parameter int COIL_COUNT = 8
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [mccs_pkg::MASK_W-1:0] cfg_data,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [1:0]                  opcode,
  input  logic [mccs_pkg::DATA_W-1:0] timer_value,
  input  logic [mccs_pkg::COIL_W-1:0] coil_index,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [mccs_pkg::COIL_W-1:0] selected_coil,
  output logic [mccs_pkg::DATA_W-1:0] read_shift,
  output logic [mccs_pkg::DATA_W-1:0] read_capture,
  output logic [mccs_pkg::DATA_W-1:0] read_tare
);

  localparam int IDX_W = $clog2(COIL_COUNT);

  mccs_pkg::state_t            state;
  mccs_pkg::state_t            state_next;
  mccs_pkg::op_t               op;
  mccs_pkg::op_t               op_q;
  mccs_pkg::rotor_ctl_t        rotor_ctl;
  logic [mccs_pkg::COIL_W-1:0] current_coil;
  logic [mccs_pkg::DATA_W-1:0] latest_capture;
  logic [COIL_COUNT-1:0]       cap_valid;
  logic [COIL_COUNT-1:0]       tare_valid;
  logic [IDX_W-1:0]            ci_addr;
  logic [IDX_W-1:0]            cur_addr;
  logic                        ci_ok;
  logic                        ci_ok_q;
  logic                        cap_vld_q;
  logic                        tare_vld_q;
  logic                        accept;
  logic                        cap_we;
  logic                        tare_we;
  logic                        rd_re;
  logic                        load_out;
  logic [mccs_pkg::DATA_W-1:0] cap_rdata;
  logic [mccs_pkg::DATA_W-1:0] tare_rdata;
  logic [mccs_pkg::DATA_W-1:0] cap_val;
  logic [mccs_pkg::DATA_W-1:0] tare_val;

  assign op        = mccs_pkg::op_t'(opcode);
  assign cfg_ready = 1'b1;
  assign in_ready  = (state == mccs_pkg::ST_IDLE);
  assign accept    = in_valid && in_ready;
  assign ci_addr   = coil_index[IDX_W-1:0];
  assign cur_addr  = current_coil[IDX_W-1:0];
  assign ci_ok     = ({1'b0, coil_index} < (mccs_pkg::COIL_W + 1)'(COIL_COUNT));
  assign cap_we    = accept && (op == mccs_pkg::OP_CAPTURE);
  assign tare_we   = accept && (op == mccs_pkg::OP_TARE) && ci_ok;
  assign rd_re     = accept && (op == mccs_pkg::OP_READ);
  assign load_out  = (state == mccs_pkg::ST_RESP) && (!out_valid || out_ready);

  assign rotor_ctl.tick    = accept && (op == mccs_pkg::OP_TICK);
  assign rotor_ctl.mask_we = cfg_valid && cfg_ready;
  assign rotor_ctl.mask    = cfg_data;

  mccs_rotor #(
    .COIL_COUNT(COIL_COUNT)
  ) u_rotor (
    .clk         (clk),
    .rst         (rst),
    .ctl         (rotor_ctl),
    .current_coil(current_coil)
  );

  mccs_ram #(
    .WIDTH(mccs_pkg::DATA_W),
    .DEPTH(COIL_COUNT)
  ) u_cap_ram (
    .clk  (clk),
    .we   (cap_we),
    .waddr(cur_addr),
    .wdata(timer_value),
    .re   (rd_re),
    .raddr(ci_addr),
    .rdata(cap_rdata)
  );

  mccs_ram #(
    .WIDTH(mccs_pkg::DATA_W),
    .DEPTH(COIL_COUNT)
  ) u_tare_ram (
    .clk  (clk),
    .we   (tare_we),
    .waddr(ci_addr),
    .wdata(latest_capture),
    .re   (rd_re),
    .raddr(ci_addr),
    .rdata(tare_rdata)
  );

  always_comb begin
    state_next = state;
    case (state)
      mccs_pkg::ST_IDLE: if (accept) state_next = mccs_pkg::ST_RESP;
      mccs_pkg::ST_RESP: if (load_out) state_next = mccs_pkg::ST_IDLE;
      default:           state_next = mccs_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cap_val  = '0;
    tare_val = '0;
    if (op_q == mccs_pkg::OP_READ && ci_ok_q) begin
      cap_val  = cap_vld_q  ? cap_rdata  : '0;
      tare_val = tare_vld_q ? tare_rdata : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= mccs_pkg::ST_IDLE;
      out_valid      <= 1'b0;
      latest_capture <= '0;
      cap_valid      <= '0;
      tare_valid     <= '0;
    end else begin
      state <= state_next;
      if (cap_we) begin
        latest_capture      <= timer_value;
        cap_valid[cur_addr] <= 1'b1;
      end
      if (tare_we) begin
        tare_valid[ci_addr] <= 1'b1;
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // hold the transaction and the valid bits seen at accept, and load the result registers
  always_ff @(posedge clk) begin
    if (accept) begin
      op_q       <= op;
      ci_ok_q    <= ci_ok;
      cap_vld_q  <= cap_valid[ci_addr];
      tare_vld_q <= tare_valid[ci_addr];
    end
    if (load_out) begin
      selected_coil <= current_coil;
      read_capture  <= cap_val;
      read_tare     <= tare_val;
      read_shift    <= (cap_val > tare_val) ? (cap_val - tare_val) : '0;
    end
  end

  a_coil_in_range: assert property (@(posedge clk) disable iff (rst)
    {1'b0, current_coil} < (mccs_pkg::COIL_W + 1)'(COIL_COUNT))
    else $error("current coil out of range");

  a_accept_to_resp: assert property (@(posedge clk) disable iff (rst)
    accept |=> state == mccs_pkg::ST_RESP)
    else $error("accepted transaction not held for response");

  a_load_releases: assert property (@(posedge clk) disable iff (rst)
    load_out |=> out_valid && state == mccs_pkg::ST_IDLE)
    else $error("result load did not release the input");

  a_shift_consistent: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (read_shift == '0 || read_shift == read_capture - read_tare))
    else $error("time shift does not match capture and tare");

endmodule
